[rtl/core/phc_pkg.sv]
// Package for the polygon half-space clipper.
// Holds register widths, register indexes, sequencer states and divider status.
// No dependencies.
package phc_pkg;

	localparam int NORM_W    = 20;
	localparam int OFF_W     = 32;
	localparam int T_BITS    = 32;
	localparam int T_HALF    = T_BITS / 2;
	localparam int MB_W      = (NORM_W > T_HALF + 1) ? NORM_W : T_HALF + 1;
	localparam int CFG_W     = OFF_W;
	localparam int CFG_IDX_W = 2;
	localparam int CNT_W     = $clog2(T_BITS + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NORMAL_X = 2'd0,
		REG_NORMAL_Y = 2'd1,
		REG_OFFSET_B = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FSX,
		S_FSY,
		S_FEX,
		S_FEY,
		S_FEND,
		S_DECIDE,
		S_DIV,
		S_LX0,
		S_LX1,
		S_LY0,
		S_LY1,
		S_LEND,
		S_EMIT_I,
		S_EMIT_E,
		S_MARK
	} state_t;

	typedef struct packed {
		logic done;
		logic full;
	} div_stat_t;

endpackage

[rtl/core/phc_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on nothing beyond its parameters.
module phc_mul #(
	parameter int A_W = 33,
	parameter int B_W = 20
) (
	input  logic                       clk,
	input  logic signed [A_W-1:0]      a,
	input  logic signed [B_W-1:0]      b,
	output logic signed [A_W+B_W-1:0]  prod
);

	logic signed [A_W+B_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

[rtl/core/phc_div.sv]
// Radix-2 restoring divider for the edge parameter t = num * 2^T_BITS / den.
// Gives a full flag when num >= den. Depends on phc_pkg.
module phc_div #(
	parameter int DW = 41
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [DW-1:0]               num,
	input  logic [DW-1:0]               den,
	output logic [phc_pkg::T_BITS-1:0]  quot,
	output phc_pkg::div_stat_t          stat
);
	import phc_pkg::*;

	logic [DW-1:0]     rem_q;
	logic [DW-1:0]     den_q;
	logic [T_BITS-1:0] quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic              full_q;
	logic [DW:0]       rem_sh;
	logic [DW:0]       rem_sub;

	assign rem_sh  = {rem_q, 1'b0};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			full_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			if (num >= den) begin
				full_q <= 1'b1;
				done_q <= 1'b1;
				busy_q <= 1'b0;
			end else begin
				full_q <= 1'b0;
				done_q <= 1'b0;
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(T_BITS);
			end
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			if (!rem_sub[DW]) begin
				rem_q <= rem_sub[DW-1:0];
				quo_q <= {quo_q[T_BITS-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DW-1:0];
				quo_q <= {quo_q[T_BITS-2:0], 1'b0};
			end
		end
	end

	assign quot      = quo_q;
	assign stat.done = done_q;
	assign stat.full = full_q;

endmodule

[rtl/core/polygon_halfspace_clipper.sv]
// Top level of the polygon half-space clipper: one Sutherland-Hodgman stage in 2D.
// Sequencer around the shared multiplier (phc_mul) and divider (phc_div); uses phc_pkg.
//
// channel  dir  handshake                    payload
// s_axis   in   s_axis_tvalid/s_axis_tready  tdata {vertex_y, vertex_x}, tlast last_vertex
// m_axis   out  m_axis_tvalid/m_axis_tready  tdata {out_y, out_x}, tuser is_end_marker,
//                                            tlast last_result
// cfg      in   cfg_we                       cfg_index, cfg_wdata
//
// Each edge computes its two clearances on the shared multiplier and loads each result
// into the output register; a crossing edge also runs the radix-2 divider and, unless t
// saturates, the interpolation multiplies. A closing vertex also runs the edge back to
// the first vertex.
// The sequencer accepts no vertex until the last result of the item is in the output
// register; a stalled output holds the sequencer. Reset needs no clearing pass.
module polygon_halfspace_clipper #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// vertex_x, vertex_y, zero fill
	input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	input  logic                              s_axis_tlast,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// out_x, out_y, zero fill
	output logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	// is_end_marker
	output logic                              m_axis_tuser,
	output logic                              m_axis_tlast,
	input  logic                              cfg_we,
	input  logic [phc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [phc_pkg::CFG_W-1:0]         cfg_wdata
);
	import phc_pkg::*;

	localparam int DATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8;
	localparam int MA_W   = COORD_WIDTH + 1;
	localparam int PROD_W = MA_W + MB_W;
	localparam int CLR_A  = PROD_W - FRAC_BITS + 2;
	localparam int CLR_W  = (CLR_A > OFF_W + 2) ? CLR_A : OFF_W + 2;
	localparam int DW     = CLR_W + 1;

	state_t state_q, state_d;

	logic signed [NORM_W-1:0]      nx_q, ny_q;
	logic signed [OFF_W-1:0]       off_q;
	logic                          mid_q, last_q, closing_q;
	logic signed [COORD_WIDTH-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic signed [COORD_WIDTH-1:0] cx_q, cy_q, sx_q, sy_q, ex_q, ey_q, ix_q, iy_q;
	logic signed [CLR_W-1:0]       fa_q, fs_q, fe_q, term;
	logic signed [PROD_W-1:0]      lacc_q;

	logic                          out_valid_q, out_end_q, out_last_q;
	logic signed [COORD_WIDTH-1:0] out_x_q, out_y_q;
	logic signed [COORD_WIDTH-1:0] emit_x, emit_y, lerp_c;
	logic                          emit_end, emit_last;

	logic signed [MA_W-1:0]        mul_a, dx, dy;
	logic signed [MB_W-1:0]        mul_b, t_lo, t_hi;
	logic signed [PROD_W-1:0]      prod;
	logic signed [PROD_W:0]        lsum, lsh;

	logic signed [DW-1:0]          fs_ext, diff;
	logic [DW-1:0]                 div_num, div_den;
	logic [T_BITS-1:0]             t_quot;
	div_stat_t                     div_stat;

	logic in_fire, load_ok, out_load, edge_end, div_start, s_in, e_in;
	state_t next_after;

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign load_ok  = !out_valid_q || m_axis_tready;
	assign s_in     = !fs_q[CLR_W-1];
	assign e_in     = !fe_q[CLR_W-1];

	assign term     = CLR_W'(prod >>> FRAC_BITS);
	assign dx       = MA_W'(ex_q) - MA_W'(sx_q);
	assign dy       = MA_W'(ey_q) - MA_W'(sy_q);
	assign t_lo     = $signed(MB_W'({1'b0, t_quot[T_HALF-1:0]}));
	assign t_hi     = $signed(MB_W'({1'b0, t_quot[T_BITS-1:T_HALF]}));
	assign lsum     = (PROD_W + 1)'(prod) + (PROD_W + 1)'(lacc_q);
	assign lsh      = lsum >>> T_HALF;

	assign fs_ext   = DW'(fs_q);
	assign diff     = fs_ext - DW'(fe_q);
	assign div_num  = fs_ext[DW-1] ? DW'(-fs_ext) : DW'(fs_ext);
	assign div_den  = diff[DW-1] ? DW'(-diff) : DW'(diff);

	phc_mul #(.A_W(MA_W), .B_W(MB_W)) u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	phc_div #(.DW(DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quot   (t_quot),
		.stat   (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		mul_a      = '0;
		mul_b      = '0;
		out_load   = 1'b0;
		edge_end   = 1'b0;
		div_start  = 1'b0;
		emit_x     = ex_q;
		emit_y     = ey_q;
		emit_end   = 1'b0;
		emit_last  = !last_q;
		next_after = closing_q ? S_FSX : (last_q ? S_MARK : S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_fire && (mid_q || s_axis_tlast)) begin
					state_d = S_FSX;
				end
			end
			S_FSX: begin
				mul_a   = MA_W'(sx_q);
				mul_b   = MB_W'(nx_q);
				state_d = S_FSY;
			end
			S_FSY: begin
				mul_a   = MA_W'(sy_q);
				mul_b   = MB_W'(ny_q);
				state_d = S_FEX;
			end
			S_FEX: begin
				mul_a   = MA_W'(ex_q);
				mul_b   = MB_W'(nx_q);
				state_d = S_FEY;
			end
			S_FEY: begin
				mul_a   = MA_W'(ey_q);
				mul_b   = MB_W'(ny_q);
				state_d = S_FEND;
			end
			S_FEND: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (s_in != e_in) begin
					div_start = 1'b1;
					state_d   = S_DIV;
				end else if (e_in) begin
					state_d = S_EMIT_E;
				end else begin
					edge_end = 1'b1;
					state_d  = next_after;
				end
			end
			S_DIV: begin
				if (div_stat.done) begin
					state_d = div_stat.full ? S_EMIT_I : S_LX0;
				end
			end
			S_LX0: begin
				mul_a   = dx;
				mul_b   = t_lo;
				state_d = S_LX1;
			end
			S_LX1: begin
				mul_a   = dx;
				mul_b   = t_hi;
				state_d = S_LY0;
			end
			S_LY0: begin
				mul_a   = dy;
				mul_b   = t_lo;
				state_d = S_LY1;
			end
			S_LY1: begin
				mul_a   = dy;
				mul_b   = t_hi;
				state_d = S_LEND;
			end
			S_LEND: begin
				state_d = S_EMIT_I;
			end
			S_EMIT_I: begin
				emit_x    = ix_q;
				emit_y    = iy_q;
				emit_last = !last_q && !e_in;
				if (load_ok) begin
					out_load = 1'b1;
					if (e_in) begin
						state_d = S_EMIT_E;
					end else begin
						edge_end = 1'b1;
						state_d  = next_after;
					end
				end
			end
			S_EMIT_E: begin
				if (load_ok) begin
					out_load = 1'b1;
					edge_end = 1'b1;
					state_d  = next_after;
				end
			end
			S_MARK: begin
				emit_x    = '0;
				emit_y    = '0;
				emit_end  = 1'b1;
				emit_last = 1'b1;
				if (load_ok) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nx_q  <= NORM_W'(65536);
			ny_q  <= '0;
			off_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NORMAL_X: nx_q  <= cfg_wdata[NORM_W-1:0];
				REG_NORMAL_Y: ny_q  <= cfg_wdata[NORM_W-1:0];
				REG_OFFSET_B: off_q <= cfg_wdata[OFF_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q       <= 1'b0;
			last_q      <= 1'b0;
			closing_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				mid_q     <= !s_axis_tlast;
				last_q    <= s_axis_tlast;
				closing_q <= mid_q && s_axis_tlast;
			end else if (edge_end && closing_q) begin
				closing_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign lerp_c = COORD_WIDTH'(lsh[COORD_WIDTH-1:0]);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cx_q     <= s_axis_tdata[COORD_WIDTH-1:0];
			cy_q     <= s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
			prev_x_q <= s_axis_tdata[COORD_WIDTH-1:0];
			prev_y_q <= s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
			ex_q     <= s_axis_tdata[COORD_WIDTH-1:0];
			ey_q     <= s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
			if (mid_q) begin
				sx_q <= prev_x_q;
				sy_q <= prev_y_q;
			end else begin
				sx_q      <= s_axis_tdata[COORD_WIDTH-1:0];
				sy_q      <= s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
				first_x_q <= s_axis_tdata[COORD_WIDTH-1:0];
				first_y_q <= s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
			end
		end else if (edge_end && closing_q) begin
			sx_q <= cx_q;
			sy_q <= cy_q;
			ex_q <= first_x_q;
			ey_q <= first_y_q;
		end
		case (state_q)
			S_FSY:  fa_q <= term - CLR_W'(off_q);
			S_FEX:  fs_q <= fa_q + term;
			S_FEY:  fa_q <= term - CLR_W'(off_q);
			S_FEND: fe_q <= fa_q + term;
			S_DIV: begin
				if (div_stat.done && div_stat.full) begin
					ix_q <= ex_q;
					iy_q <= ey_q;
				end
			end
			S_LX1:  lacc_q <= prod >>> T_HALF;
			S_LY0:  ix_q   <= sx_q + lerp_c;
			S_LY1:  lacc_q <= prod >>> T_HALF;
			S_LEND: iy_q   <= sy_q + lerp_c;
			default: ;
		endcase
		if (out_load) begin
			out_x_q    <= emit_x;
			out_y_q    <= emit_y;
			out_end_q  <= emit_end;
			out_last_q <= emit_last;
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = DATA_W'({out_y_q, out_x_q});
	assign m_axis_tuser  = out_end_q;
	assign m_axis_tlast  = out_last_q;

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == S_DIV)
		else $error("divider finished outside its wait state");

	a_marker_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == '0)
		else $error("end marker without zero coordinates or last flag");

	a_marker_closes: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MARK |-> !mid_q && last_q && !closing_q)
		else $error("end marker while polygon still open");

	a_accept_idle_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> state_q != S_IDLE && !in_fire)
		else $error("result loaded while taking a vertex");

endmodule
